// File: rtl/tsf_pkg.sv
// shared types and constants of the transport-stream packet sync framer
package tsf_pkg;

    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 32;
    localparam int PACKET_BYTES_DEF = 188;
    localparam int LOCK_PACKETS_DEF = 3;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_byte SYNC_RESET = 8'h47;

    typedef struct packed {
        logic valid;
        logic fill;
    } t_step_ctl;

endpackage

// File: rtl/tsf_if.sv
// request channels of the framer: byte input, configuration write, framed output
interface tsf_in_if;
    import tsf_pkg::*;
    logic  valid;
    logic  ready;
    t_byte in_byte;
    modport source(output valid, output in_byte, input ready);
    modport sink(input valid, input in_byte, output ready);
endinterface

interface tsf_cfg_if;
    import tsf_pkg::*;
    logic  valid;
    logic  ready;
    t_byte sync_value;
    modport source(output valid, output sync_value, input ready);
    modport sink(input valid, input sync_value, output ready);
endinterface

interface tsf_out_if;
    import tsf_pkg::*;
    logic   valid;
    logic   ready;
    t_byte  out_byte;
    logic   packet_start;
    logic   locked;
    t_count packet_total;
    t_count drop_total;
    modport source(output valid, output out_byte, output packet_start, output locked,
                   output packet_total, output drop_total, input ready);
    modport sink(input valid, input out_byte, input packet_start, input locked,
                 input packet_total, input drop_total, output ready);
endinterface

// File: rtl/tsf_ring_ram.sv
// delay ring memory: one row per packet offset, one byte lane per delayed packet
module tsf_ring_ram #(
    parameter int ROWS   = tsf_pkg::PACKET_BYTES_DEF,
    parameter int LANES  = tsf_pkg::LOCK_PACKETS_DEF - 1,
    parameter int ROW_W  = $clog2(ROWS),
    parameter int LANE_W = (LANES > 1) ? $clog2(LANES) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [ROW_W-1:0]                i_row,
    input  logic [LANE_W-1:0]               i_lane,
    input  tsf_pkg::t_byte                  i_wdata,
    output tsf_pkg::t_byte [LANES-1:0]      o_rdata
);
    import tsf_pkg::*;

    t_byte [LANES-1:0] r_mem [ROWS];
    t_byte [LANES-1:0] r_rdata;

    // read returns the row before this write
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata               <= r_mem[i_row];
            r_mem[i_row][i_lane]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tsf_sync_ctrl.sv
// sync search, lock tracking, saturating counters and output register
module tsf_sync_ctrl #(
    parameter int PACKET_BYTES = tsf_pkg::PACKET_BYTES_DEF,
    parameter int LOCK_PACKETS = tsf_pkg::LOCK_PACKETS_DEF,
    parameter int LANE_W       = (LOCK_PACKETS > 2) ? $clog2(LOCK_PACKETS - 1) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tsf_pkg::t_byte                         i_sync,
    input  tsf_pkg::t_step_ctl                     i_step,
    input  logic [LANE_W-1:0]                      i_lane,
    input  tsf_pkg::t_byte                         i_byte,
    input  tsf_pkg::t_byte [LOCK_PACKETS-2:0]      i_row,
    output logic                                   o_done,
    tsf_out_if.source                              o_out
);
    import tsf_pkg::*;

    localparam int LANES = LOCK_PACKETS - 1;
    localparam int PH_W  = $clog2(PACKET_BYTES);
    localparam int PRE_W = $clog2(LOCK_PACKETS + 1);

    function automatic t_count sat_add(t_count a, t_count b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
    endfunction

    logic             r_lock, n_lock;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [PRE_W-1:0] r_pre, n_pre;
    t_count           r_acc, n_acc;
    t_count           r_loss, n_loss;
    logic             r_out_valid;
    t_byte            r_out_byte;
    logic             r_out_start;
    t_count           r_out_acc;
    t_count           r_out_loss;

    logic  win;
    logic  go;
    logic  emit;
    logic  start;
    logic  fire;
    logic  out_free;
    t_byte oldest;

    always_comb begin
        n_lock  = r_lock;
        n_phase = r_phase;
        n_pre   = r_pre;
        n_acc   = r_acc;
        n_loss  = r_loss;
        go      = 1'b0;
        emit    = 1'b0;
        start   = 1'b0;
        oldest  = i_row[i_lane];
        win     = (i_byte == i_sync);
        for (int k = 0; k < LANES; k++) begin
            win = win && (i_row[k] == i_sync);
        end
        if (i_step.valid && !i_step.fill) begin
            go = 1'b1;
            if (!r_lock) begin
                if (!win) begin
                    go = 1'b0;
                end else begin
                    n_lock  = 1'b1;
                    n_acc   = sat_add(r_acc, COUNT_W'(LOCK_PACKETS));
                    n_pre   = PRE_W'(LOCK_PACKETS);
                    n_phase = '0;
                end
            end
            if (go) begin
                start = (n_phase == '0);
                if (start) begin
                    if (n_pre != '0) begin
                        n_pre = n_pre - PRE_W'(1);
                    end else if (oldest == i_sync) begin
                        n_acc = sat_add(r_acc, COUNT_W'(1));
                    end else begin
                        n_loss = sat_add(r_loss, COUNT_W'(1));
                        n_lock = 1'b0;
                        go     = 1'b0;
                    end
                end
                if (go) begin
                    emit    = 1'b1;
                    n_phase = (n_phase == PH_W'(PACKET_BYTES - 1)) ? '0 : n_phase + PH_W'(1);
                end
            end
        end
    end

    assign out_free = !r_out_valid || o_out.ready;
    assign o_done   = !emit || out_free;
    assign fire     = i_step.valid && o_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock      <= 1'b0;
            r_phase     <= '0;
            r_pre       <= '0;
            r_acc       <= '0;
            r_loss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_lock  <= n_lock;
                r_phase <= n_phase;
                r_pre   <= n_pre;
                r_acc   <= n_acc;
                r_loss  <= n_loss;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_byte  <= oldest;
            r_out_start <= start;
            r_out_acc   <= n_acc;
            r_out_loss  <= n_loss;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.packet_start = r_out_start;
    assign o_out.locked       = 1'b1;
    assign o_out.packet_total = r_out_acc;
    assign o_out.drop_total   = r_out_loss;

    a_pre_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre != '0 |-> r_lock)
        else $error("pending prevalidated packets while unlocked");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_W'(PACKET_BYTES - 1))
        else $error("packet phase out of range");

    a_acc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_acc >= $past(r_acc))
        else $error("packet count decreased");

    a_loss_unlocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_loss != $past(r_loss)) |-> !r_lock)
        else $error("sync loss counted without unlock");

endmodule

// File: rtl/ts_packet_sync_framer.sv
// top level of the transport-stream packet sync framer
// Takes one stream byte per clock while the output side takes results, and a result
// passes through the stage-one register and then the output register; a stall on the
// output side can hold it in stage one, and that holds the input as well.
// The delay line lives in one memory of PACKET_BYTES rows, each row holding
// LOCK_PACKETS-1 bytes that lie one packet apart, so one row read per byte gives the
// whole sync window; the single read-modify-write port on that memory sets the rate
// at one byte per cycle. The first (LOCK_PACKETS-1)*PACKET_BYTES bytes after reset
// only fill the delay line and give no result. Results appear only while locked.
module ts_packet_sync_framer #(
    parameter int PACKET_BYTES = tsf_pkg::PACKET_BYTES_DEF,
    parameter int LOCK_PACKETS = tsf_pkg::LOCK_PACKETS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsf_in_if.sink    i_in,
    tsf_cfg_if.sink   i_cfg,
    tsf_out_if.source o_out
);
    import tsf_pkg::*;

    localparam int LANES  = LOCK_PACKETS - 1;
    localparam int ROW_W  = $clog2(PACKET_BYTES);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    t_byte             r_sync;
    logic [ROW_W-1:0]  r_row;
    logic [LANE_W-1:0] r_lane;
    logic              r_filled;
    t_step_ctl         r_s1;
    logic [LANE_W-1:0] r_s1_lane;
    t_byte             r_s1_byte;

    t_byte [LANES-1:0] ram_rdata;
    logic              s1_done;
    logic              in_fire;
    logic              row_last;
    logic              lane_last;

    assign i_in.ready  = !r_s1.valid || s1_done;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign row_last    = (r_row == ROW_W'(PACKET_BYTES - 1));
    assign lane_last   = (r_lane == LANE_W'(LANES - 1));

    // ring address: row is offset within a packet, lane is which delayed packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= SYNC_RESET;
            r_row    <= '0;
            r_lane   <= '0;
            r_filled <= 1'b0;
            r_s1     <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_sync <= i_cfg.sync_value;
            end
            if (in_fire) begin
                r_s1 <= '{valid: 1'b1, fill: !r_filled};
                if (row_last) begin
                    r_row  <= '0;
                    r_lane <= lane_last ? '0 : r_lane + LANE_W'(1);
                    if (lane_last) begin
                        r_filled <= 1'b1;
                    end
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else if (s1_done) begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_lane <= r_lane;
            r_s1_byte <= i_in.in_byte;
        end
    end

    tsf_ring_ram #(
        .ROWS   (PACKET_BYTES),
        .LANES  (LANES),
        .ROW_W  (ROW_W),
        .LANE_W (LANE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (in_fire),
        .i_row   (r_row),
        .i_lane  (r_lane),
        .i_wdata (i_in.in_byte),
        .o_rdata (ram_rdata)
    );

    tsf_sync_ctrl #(
        .PACKET_BYTES (PACKET_BYTES),
        .LOCK_PACKETS (LOCK_PACKETS),
        .LANE_W       (LANE_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sync  (r_sync),
        .i_step  (r_s1),
        .i_lane  (r_s1_lane),
        .i_byte  (r_s1_byte),
        .i_row   (ram_rdata),
        .o_done  (s1_done),
        .o_out   (o_out)
    );

endmodule
